// ===== rtl/gpps_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Gaussian elimination solver.
// No dependencies; gpps_div and the solver top import this package.
`default_nettype none

package gpps_pkg;

  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 4;
  localparam int THR_W     = 31;
  localparam int REG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_SYSTEM_SIZE        = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SINGULAR_THRESHOLD = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
    return a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  endfunction

  // Clamp a wide signed value to the 32-bit range and flag the clamp.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = DATA_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = DATA_W'(SAT_MIN);
    end else begin
      r.ovf = 1'b0;
      r.val = DATA_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gpps_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module gpps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gpps_div.sv =====
// Restoring divider, one quotient bit per cycle, for unsigned magnitudes.
// Depends on gpps_pkg for the status struct.
`default_nettype none

module gpps_div import gpps_pkg::*; #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quot,
  output div_sts_t              sts
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] qsh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             zden;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, qsh[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, dreg});
  // A zero divisor gives a zero quotient.
  assign quot   = zden ? '0 : qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
      cnt      <= '0;
    end else begin
      sts.done <= 1'b0;
      if (start) begin
        qsh      <= num;
        rem      <= '0;
        dreg     <= den;
        zden     <= (den == '0);
        cnt      <= CNT_W'(NUM_W);
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        rem <= fits ? DEN_W'(rem_sh - {1'b0, dreg}) : DEN_W'(rem_sh);
        qsh <= {qsh[NUM_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gauss_partial_pivot_solver.sv =====
// Top level of the Gaussian elimination solver with partial pivoting.
// Depends on gpps_pkg, gpps_ram (load and work memories) and gpps_div.
//
//   Channel  Signals                                           Direction
//   -------  ------------------------------------------------  ---------
//   config   cfg_write, cfg_index, cfg_data                    in
//   input    in_valid/in_stall, row_index, col_index,          in
//            coef_value, last_entry
//   result   out_valid/out_stall, unknown_index, sol_value,    out
//            status, last_result
//
// The load channel takes entries while the solver is idle. The beat marked last starts a solve that first copies
// the MAX_SIZE*(MAX_SIZE+1) entries of the load memory into the work memory, one entry a
// cycle. Each division runs through the bit-serial divider, which forms a 33+FRAC_BITS-bit
// quotient, and divisions set the solve time: n*(n+1)/2 of them, plus a multiply and round
// for each updated entry and each back-substitution product; a solve takes a little longer
// when rows are swapped.
// The input stalls for the whole solve and result delivery; a result waits in the output
// register under out_stall. Reset is synchronous and clears control state only.
`default_nettype none

module gauss_partial_pivot_solver import gpps_pkg::*; #(
  parameter int MAX_SIZE  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [REG_IDX_W-1:0]     cfg_index,
  input  wire logic [THR_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               row_index,
  input  wire logic [3:0]               col_index,
  input  wire logic signed [DATA_W-1:0] coef_value,
  input  wire logic                     last_entry,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    unknown_index,
  output logic signed [DATA_W-1:0]      sol_value,
  output logic [1:0]                    status,
  output logic                          last_result
);

  // Rows hold MAX_SIZE coefficients and then the right-hand side.
  localparam int COLS     = MAX_SIZE + 1;
  localparam int LDEPTH   = MAX_SIZE * COLS;
  localparam int WDEPTH   = LDEPTH + MAX_SIZE;   // solution vector follows the matrix
  localparam int LAW      = $clog2(LDEPTH);
  localparam int WAW      = $clog2(WDEPTH);
  localparam int IW       = $clog2(MAX_SIZE + 1);
  localparam int ACC_W    = DATA_W + IW + 1;
  localparam int NUM_W    = DATA_W + FRAC_BITS + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_COPY   = 5'd1;
  localparam logic [4:0] S_PS_RD  = 5'd2;
  localparam logic [4:0] S_PS_CMP = 5'd3;
  localparam logic [4:0] S_PS_CHK = 5'd4;
  localparam logic [4:0] S_SING   = 5'd5;
  localparam logic [4:0] S_SW_RA  = 5'd6;
  localparam logic [4:0] S_SW_RB  = 5'd7;
  localparam logic [4:0] S_SW_WA  = 5'd8;
  localparam logic [4:0] S_SW_WB  = 5'd9;
  localparam logic [4:0] S_E_ROW  = 5'd10;
  localparam logic [4:0] S_E_RD   = 5'd11;
  localparam logic [4:0] S_E_DIV  = 5'd12;
  localparam logic [4:0] S_E_DIVW = 5'd13;
  localparam logic [4:0] S_E_RPJ  = 5'd14;
  localparam logic [4:0] S_E_RIJ  = 5'd15;
  localparam logic [4:0] S_E_MUL  = 5'd16;
  localparam logic [4:0] S_E_RND  = 5'd17;
  localparam logic [4:0] S_E_WR   = 5'd18;
  localparam logic [4:0] S_B_INIT = 5'd19;
  localparam logic [4:0] S_B_RA   = 5'd20;
  localparam logic [4:0] S_B_RX   = 5'd21;
  localparam logic [4:0] S_B_MUL  = 5'd22;
  localparam logic [4:0] S_B_RND  = 5'd23;
  localparam logic [4:0] S_B_ACC  = 5'd24;
  localparam logic [4:0] S_B_RF   = 5'd25;
  localparam logic [4:0] S_B_RP   = 5'd26;
  localparam logic [4:0] S_B_DIV  = 5'd27;
  localparam logic [4:0] S_B_DIVW = 5'd28;
  localparam logic [4:0] S_O_RD   = 5'd29;
  localparam logic [4:0] S_O_LD   = 5'd30;

  // Address of a matrix cell in either memory.
  function automatic logic [WAW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return WAW'(r) * WAW'(COLS) + WAW'(c);
  endfunction

  function automatic logic [WAW-1:0] sol_addr(input logic [IW-1:0] r);
    return WAW'(LDEPTH) + WAW'(r);
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0] system_size;
  logic [THR_W-1:0]  singular_threshold;

  // Sequencer state and loop counters.
  logic [4:0]    state;
  logic [IW-1:0] k;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] best;
  logic [IW-1:0] n_use;
  logic [IW-1:0] n_m1;
  logic [IW-1:0] j_step;

  // Datapath registers.
  logic [DATA_W-1:0]        bmag;
  logic signed [DATA_W-1:0] piv;
  logic signed [DATA_W-1:0] tmp_a;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] s_val;
  logic signed [DATA_W-1:0] wij;
  logic signed [DATA_W-1:0] p_val;
  logic signed [DATA_W-1:0] dsat;
  logic signed [ACC_W-1:0]  acc;
  logic [63:0]              prod;
  logic                     pneg;
  logic                     div_neg;
  logic                     ovf;

  // Copy sweep.
  logic [WAW-1:0] copy_cnt;
  logic [WAW-1:0] copy_addr;
  logic           copy_pend;

  // Memory ports.
  logic              l_we;
  logic [LAW-1:0]    l_waddr;
  logic [DATA_W-1:0] l_rdata;
  logic              w_we;
  logic [WAW-1:0]    w_waddr;
  logic [DATA_W-1:0] w_wdata;
  logic [WAW-1:0]    w_raddr;
  logic signed [DATA_W-1:0] w_rdata;

  // Arithmetic.
  logic signed [DATA_W-1:0] mul_b;
  logic [63:0]              prod_next;
  logic [63:0]              rnd;
  sat_t                     p_sat;
  sat_t                     e_diff;
  sat_t                     b_diff;
  sat_t                     q_sat;
  logic signed [DATA_W-1:0] div_a;
  logic signed [DATA_W-1:0] div_b;
  logic [NUM_W-1:0]         div_num;
  logic [NUM_W-1:0]         div_quot;
  logic                     div_start;
  div_sts_t                 div_sts;
  logic [DATA_W-1:0]        cur_mag;

  logic in_acc;
  logic store_ok;
  logic out_free;
  logic out_load;

  // Size in use: zero acts as one, anything above MAX_SIZE as MAX_SIZE.
  always_comb begin
    if (system_size == '0) begin
      n_use = IW'(1);
    end else if (32'(system_size) > 32'(MAX_SIZE)) begin
      n_use = IW'(MAX_SIZE);
    end else begin
      n_use = IW'(system_size);
    end
  end
  assign n_m1   = n_use - IW'(1);
  // Column walk: used coefficients, then the right-hand side.
  assign j_step = (j == n_m1) ? IW'(MAX_SIZE) : j + IW'(1);

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // A new result beat enters the output register this cycle.
  assign out_load = out_free && (state == S_SING || state == S_O_LD);

  // Entries with a column outside the system in use are dropped.
  assign store_ok = (32'(row_index) < 32'(MAX_SIZE)) && (32'(col_index) <= 32'(n_use));
  assign l_we     = in_acc && store_ok;
  assign l_waddr  = LAW'(cell_addr(IW'(row_index),
                      (32'(col_index) == 32'(n_use)) ? IW'(MAX_SIZE) : IW'(col_index)));

  gpps_ram #(.WIDTH(DATA_W), .DEPTH(LDEPTH)) u_load_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (coef_value),
    .raddr (LAW'(copy_cnt)),
    .rdata (l_rdata)
  );

  gpps_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_work_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Product: exact magnitude product, round half away from zero, then clamp.
  assign mul_b     = (state == S_B_MUL) ? w_rdata : s_val;
  assign prod_next = mag(mul_a) * mag(mul_b);
  assign rnd       = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign p_sat     = sat32(pneg ? -$signed(rnd) : $signed(rnd));

  assign e_diff = sat32(64'(wij) - 64'(p_val));
  assign b_diff = sat32(64'(w_rdata) - 64'(acc));

  // Quotient: (|a|*2^F + |b|/2) / |b|, sign applied, then clamped.
  assign div_a     = (state == S_E_DIV) ? w_rdata : dsat;
  assign div_b     = (state == S_E_DIV) ? piv : w_rdata;
  assign div_start = (state == S_E_DIV) || (state == S_B_DIV);
  assign div_num   = (NUM_W'(mag(div_a)) << FRAC_BITS) + NUM_W'(mag(div_b) >> 1);
  assign q_sat     = sat32(div_neg ? -$signed(64'(div_quot)) : $signed(64'(div_quot)));

  gpps_div #(.NUM_W(NUM_W), .DEN_W(DATA_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (mag(div_b)),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  assign cur_mag = mag(w_rdata);

  // Work memory access per state. The last copy write lands in the first
  // pivot-search cycle, which reads a different cell.
  always_comb begin
    w_we    = copy_pend;
    w_waddr = copy_addr;
    w_wdata = l_rdata;
    w_raddr = '0;
    case (state)
      S_PS_RD:  w_raddr = cell_addr(i, k);
      S_SW_RA:  w_raddr = cell_addr(k, j);
      S_SW_RB:  w_raddr = cell_addr(best, j);
      S_SW_WA: begin
        w_we    = 1'b1;
        w_waddr = cell_addr(k, j);
        w_wdata = w_rdata;
      end
      S_SW_WB: begin
        w_we    = 1'b1;
        w_waddr = cell_addr(best, j);
        w_wdata = tmp_a;
      end
      S_E_RD:   w_raddr = cell_addr(i, k);
      S_E_RPJ:  w_raddr = cell_addr(k, j);
      S_E_RIJ:  w_raddr = cell_addr(i, j);
      S_E_WR: begin
        w_we    = 1'b1;
        w_waddr = cell_addr(i, j);
        w_wdata = e_diff.val;
      end
      S_B_RA:   w_raddr = cell_addr(k, j);
      S_B_RX:   w_raddr = sol_addr(j);
      S_B_RF:   w_raddr = cell_addr(k, IW'(MAX_SIZE));
      S_B_RP:   w_raddr = cell_addr(k, k);
      S_B_DIVW: begin
        w_we    = div_sts.done;
        w_waddr = sol_addr(k);
        w_wdata = q_sat.val;
      end
      S_O_RD, S_O_LD: w_raddr = sol_addr(i);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      system_size        <= SIZE_W'(8);
      singular_threshold <= THR_W'(1);
      out_valid          <= 1'b0;
      ovf                <= 1'b0;
      copy_pend          <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SYSTEM_SIZE:        system_size        <= cfg_data[SIZE_W-1:0];
          REG_SINGULAR_THRESHOLD: singular_threshold <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end

      copy_pend <= (state == S_COPY);
      copy_addr <= copy_cnt;

      unique case (state)
        S_IDLE: begin
          if (in_acc && last_entry) begin
            copy_cnt <= '0;
            ovf      <= 1'b0;
            state    <= S_COPY;
          end
        end
        S_COPY: begin
          copy_cnt <= copy_cnt + WAW'(1);
          if (copy_cnt == WAW'(LDEPTH - 1)) begin
            k     <= '0;
            i     <= '0;
            state <= S_PS_RD;
          end
        end
        S_PS_RD: state <= S_PS_CMP;
        S_PS_CMP: begin
          // First maximum wins.
          if (i == k || cur_mag > bmag) begin
            bmag <= cur_mag;
            best <= i;
            piv  <= w_rdata;
          end
          if (i == n_m1) begin
            state <= S_PS_CHK;
          end else begin
            i     <= i + IW'(1);
            state <= S_PS_RD;
          end
        end
        S_PS_CHK: begin
          j <= k;
          i <= k + IW'(1);
          if (piv == '0 || bmag < {1'b0, singular_threshold}) begin
            state <= S_SING;
          end else if (best != k) begin
            state <= S_SW_RA;
          end else begin
            state <= S_E_ROW;
          end
        end
        S_SING: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            unknown_index <= '0;
            sol_value     <= '0;
            status        <= STATUS_SINGULAR;
            last_result   <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SW_RA: state <= S_SW_RB;
        S_SW_RB: begin
          tmp_a <= w_rdata;
          state <= S_SW_WA;
        end
        S_SW_WA: state <= S_SW_WB;
        S_SW_WB: begin
          if (j == IW'(MAX_SIZE)) begin
            state <= S_E_ROW;
          end else begin
            j     <= j_step;
            state <= S_SW_RA;
          end
        end
        S_E_ROW: begin
          if (i == n_use) begin
            if (k == n_m1) begin
              state <= S_B_INIT;
            end else begin
              k     <= k + IW'(1);
              i     <= k + IW'(1);
              state <= S_PS_RD;
            end
          end else begin
            state <= S_E_RD;
          end
        end
        S_E_RD: state <= S_E_DIV;
        S_E_DIV: begin
          div_neg <= w_rdata[DATA_W-1] ^ piv[DATA_W-1];
          state   <= S_E_DIVW;
        end
        S_E_DIVW: begin
          if (div_sts.done) begin
            s_val <= q_sat.val;
            ovf   <= ovf | q_sat.ovf;
            j     <= (k + IW'(1) == n_use) ? IW'(MAX_SIZE) : k + IW'(1);
            state <= S_E_RPJ;
          end
        end
        S_E_RPJ: state <= S_E_RIJ;
        S_E_RIJ: begin
          mul_a <= w_rdata;
          state <= S_E_MUL;
        end
        S_E_MUL: begin
          wij   <= w_rdata;
          prod  <= prod_next;
          pneg  <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
          state <= S_E_RND;
        end
        S_E_RND: begin
          p_val <= p_sat.val;
          ovf   <= ovf | p_sat.ovf;
          state <= S_E_WR;
        end
        S_E_WR: begin
          ovf <= ovf | e_diff.ovf;
          if (j == IW'(MAX_SIZE)) begin
            i     <= i + IW'(1);
            state <= S_E_ROW;
          end else begin
            j     <= j_step;
            state <= S_E_RPJ;
          end
        end
        S_B_INIT: begin
          acc <= '0;
          j   <= k + IW'(1);
          if (k + IW'(1) == n_use) begin
            state <= S_B_RF;
          end else begin
            state <= S_B_RA;
          end
        end
        S_B_RA: state <= S_B_RX;
        S_B_RX: begin
          mul_a <= w_rdata;
          state <= S_B_MUL;
        end
        S_B_MUL: begin
          prod  <= prod_next;
          pneg  <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
          state <= S_B_RND;
        end
        S_B_RND: begin
          p_val <= p_sat.val;
          ovf   <= ovf | p_sat.ovf;
          state <= S_B_ACC;
        end
        S_B_ACC: begin
          acc <= acc + ACC_W'(p_val);
          if (j + IW'(1) == n_use) begin
            state <= S_B_RF;
          end else begin
            j     <= j + IW'(1);
            state <= S_B_RA;
          end
        end
        S_B_RF: state <= S_B_RP;
        S_B_RP: begin
          dsat  <= b_diff.val;
          ovf   <= ovf | b_diff.ovf;
          state <= S_B_DIV;
        end
        S_B_DIV: begin
          div_neg <= dsat[DATA_W-1] ^ w_rdata[DATA_W-1];
          state   <= S_B_DIVW;
        end
        S_B_DIVW: begin
          if (div_sts.done) begin
            ovf <= ovf | q_sat.ovf;
            if (k == '0) begin
              i     <= '0;
              state <= S_O_RD;
            end else begin
              k     <= k - IW'(1);
              state <= S_B_INIT;
            end
          end
        end
        S_O_RD: state <= S_O_LD;
        S_O_LD: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            unknown_index <= 3'(i);
            sol_value     <= w_rdata;
            status        <= ovf ? STATUS_SAT : STATUS_OK;
            last_result   <= (i == n_m1);
            if (i == n_m1) begin
              state <= S_IDLE;
            end else begin
              i     <= i + IW'(1);
              state <= S_O_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider is only started once the previous division has finished.
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // A finished division is only ever seen by a state that waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_E_DIVW || state == S_B_DIVW))
    else $error("division finished with nobody waiting");

  // Elimination never writes into the solution area of the work memory.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_E_WR) |-> (w_waddr < WAW'(LDEPTH)))
    else $error("elimination write outside the matrix");

  // A singular verdict is a lone zero result that closes the solve.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_SINGULAR) |-> (last_result && sol_value == '0))
    else $error("malformed singular result");

endmodule

`default_nettype wire

// ===== tb/gpps_checker.sv =====
// Checker for the Gaussian elimination solver: watches the register port and both channels,
// predicts every solve in fixed point and compares the result beats in order.
// Depends on gpps_pkg for the register indexes and status codes.
module gpps_checker import gpps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [THR_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [2:0]               row_index,
  input  logic [3:0]               col_index,
  input  logic signed [DATA_W-1:0] coef_value,
  input  logic                     last_entry,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [2:0]               unknown_index,
  input  logic signed [DATA_W-1:0] sol_value,
  input  logic [1:0]               status,
  input  logic                     last_result,
  output int                       errors,
  output int                       pending,
  output int                       solves,
  output int                       singulars,
  output int                       saturated
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = 8;

  typedef struct packed {
    logic [2:0]               idx;
    logic signed [DATA_W-1:0] val;
    logic [1:0]               st;
    logic                     last;
  } solution_beat_t;

  solution_beat_t expected_solutions[$];

  logic signed [DATA_W-1:0] loaded[NMAX][NMAX+1];
  logic signed [DATA_W-1:0] unknowns[NMAX];
  logic [SIZE_W-1:0]        size_reg;
  logic [THR_W-1:0]         thresh_reg;
  logic                     clamp_seen;

  assign pending = expected_solutions.size();

  function automatic int unsigned active_size();
    if (size_reg == 0) return 1;
    if (size_reg > NMAX) return NMAX;
    return size_reg;
  endfunction

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // Clamp a magnitude with sign to 32 bits, noting any clamp for the status.
  function automatic logic signed [DATA_W-1:0] clamp(bit neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        clamp_seen = 1'b1;
        m = 64'h8000_0000;
      end
      return DATA_W'(-longint'(m));
    end
    if (m > 64'h7FFF_FFFF) begin
      clamp_seen = 1'b1;
      m = 64'h7FFF_FFFF;
    end
    return DATA_W'(m);
  endfunction

  function automatic logic signed [DATA_W-1:0] qmul(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    logic [63:0] m;
    m = (magnitude(a) * magnitude(b) + 64'h8000) >> 16;
    return clamp((a < 0) != (b < 0), m);
  endfunction

  function automatic logic signed [DATA_W-1:0] qdiv(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    logic [63:0] d;
    logic [63:0] q;
    d = magnitude(b);
    if (d == 0) return '0;
    q = ((magnitude(a) << 16) + d / 2) / d;
    return clamp((a < 0) != (b < 0), q);
  endfunction

  function automatic logic signed [DATA_W-1:0] qsub(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return clamp(d < 0, magnitude(d));
  endfunction

  // Eliminate with row pivoting on a copy of the loaded matrix, then back-substitute.
  task automatic solve_loaded_system();
    logic signed [DATA_W-1:0] w[NMAX][NMAX+1];
    int unsigned order[NMAX];
    int unsigned n, best, pr, r, tmp;
    logic [63:0] bmag, m;
    logic signed [DATA_W-1:0] piv, s;
    longint acc, d;
    solution_beat_t b;
    w = loaded;
    n = active_size();
    for (int i = 0; i < NMAX; i++) order[i] = i;
    clamp_seen = 1'b0;
    solves++;
    for (int k = 0; k < n; k++) begin
      best = k;
      bmag = magnitude(w[order[k]][k]);
      for (int i = k + 1; i < n; i++) begin
        m = magnitude(w[order[i]][k]);
        if (m > bmag) begin
          bmag = m;
          best = i;
        end
      end
      tmp = order[k];
      order[k] = order[best];
      order[best] = tmp;
      pr = order[k];
      piv = w[pr][k];
      if (piv == 0 || bmag < 64'(thresh_reg)) begin
        b = '{idx: 3'd0, val: '0, st: STATUS_SINGULAR, last: 1'b1};
        expected_solutions.push_back(b);
        singulars++;
        return;
      end
      for (int i = k + 1; i < n; i++) begin
        r = order[i];
        s = qdiv(w[r][k], piv);
        for (int j = k + 1; j < n; j++) w[r][j] = qsub(w[r][j], qmul(w[pr][j], s));
        w[r][NMAX] = qsub(w[r][NMAX], qmul(s, w[pr][NMAX]));
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      r = order[k];
      acc = 0;
      for (int j = k + 1; j < n; j++) acc += longint'(qmul(w[r][j], unknowns[j]));
      d = longint'(w[r][NMAX]) - acc;
      unknowns[k] = qdiv(clamp(d < 0, magnitude(d)), w[r][k]);
    end
    if (clamp_seen) saturated++;
    for (int i = 0; i < n; i++) begin
      b.idx  = 3'(i);
      b.val  = unknowns[i];
      b.st   = clamp_seen ? STATUS_SAT : STATUS_OK;
      b.last = (i == n - 1);
      expected_solutions.push_back(b);
    end
  endtask

  task automatic note_mismatch(string what, solution_beat_t exp_b, solution_beat_t got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch (%s): expected idx %0d val %0d st %0d last %0d, got idx %0d val %0d st %0d last %0d",
               $realtime, what, exp_b.idx, exp_b.val, exp_b.st, exp_b.last,
               got.idx, got.val, got.st, got.last);
  endtask

  always @(posedge clk) begin
    solution_beat_t got;
    solution_beat_t exp_b;
    int unsigned n;
    if (rst) begin
      size_reg   <= 4'd8;
      thresh_reg <= 31'd1;
      expected_solutions.delete();
      errors    = 0;
      solves    = 0;
      singulars = 0;
      saturated = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{idx: unknown_index, val: sol_value, st: status, last: last_result};
        if (expected_solutions.size() == 0) begin
          note_mismatch("no result expected", '0, got);
        end else begin
          exp_b = expected_solutions.pop_front();
          if (got !== exp_b) note_mismatch("field", exp_b, got);
        end
      end
      if (in_valid && !in_stall) begin
        n = active_size();
        if (col_index == n) loaded[row_index][NMAX] = coef_value;
        else if (col_index < n) loaded[row_index][col_index] = coef_value;
        if (last_entry) solve_loaded_system();
      end
      // Register writes land after the beat of this edge was handled.
      if (cfg_write) begin
        if (cfg_index == REG_SYSTEM_SIZE) size_reg <= cfg_data[SIZE_W-1:0];
        else if (cfg_index == REG_SINGULAR_THRESHOLD) thresh_reg <= cfg_data;
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Top of the solver testbench: clock, reset, register writes, load beats and result stalls.
// Depends on gpps_pkg, the solver RTL and gpps_checker, which does all the checking.
module tb import gpps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = REG_SYSTEM_SIZE;
  logic [THR_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               row_index = '0;
  logic [3:0]               col_index = '0;
  logic signed [DATA_W-1:0] coef_value = '0;
  logic                     last_entry = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               unknown_index;
  logic signed [DATA_W-1:0] sol_value;
  logic [1:0]               status;
  logic                     last_result;

  int errors, pending, solves, singulars, saturated;

  // Sender state: how many beats remain in the current burst, and whether gaps are on.
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  loaded_beats = 0;
  int  noise_beats = 0;
  // The receiver holds off once the top asks for it; hold_left counts the hold down.
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  cycle = 0;

  always #5 clk = ~clk;

  gauss_partial_pivot_solver dut (.*);

  gpps_checker chk (.*);

  // The receiver steps through stall patterns in turn: none, light random,
  // heavy random and a fixed period. A long hold overrides the pattern while it runs.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= 1500;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      case ((cycle / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cycle % 5 < 2);
      endcase
    end
  end

  // Give up well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // One write per call; the trailing edge keeps back-to-back writes apart.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid   <= 1'b0;
    last_entry <= 1'b0;
    burst_left = 0;
  endtask

  // Pause the sender until every predicted result has arrived, then let the block settle.
  task automatic wait_idle();
    stop_sending();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one beat and hold it until the block takes it. Bursts are split by a random gap when gaps are on.
  task automatic send_beat(logic [2:0] r, logic [3:0] c, logic signed [DATA_W-1:0] v,
                           bit last);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    row_index  <= r;
    col_index  <= c;
    coef_value <= v;
    last_entry <= last;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic int unsigned used_size(int unsigned reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > 8) return 8;
    return reg_val;
  endfunction

  // Entry values by system kind: 0 diagonal-heavy (no entry above its row's diagonal), 1 full range, 2 singular.
  function automatic logic signed [DATA_W-1:0] pick_value(int kind, int r, int c,
                                                          int unsigned n);
    logic signed [DATA_W-1:0] v;
    case (kind)
      0: begin
        v = $signed($urandom_range(0, 262144)) - 131072;
        if (r == c) v = $signed(($urandom_range(2, 8) << 16) + $urandom_range(0, 65535))
                        * ($urandom_range(0, 1) ? 1 : -1);
      end
      1: v = $urandom;
      default: begin
        v = $signed($urandom_range(0, 262144)) - 131072;
        if (c == 0 && c != n) v = '0;
      end
    endcase
    return v;
  endfunction

  // Load the whole augmented system in shuffled order with some out-of-system beats mixed
  // in; the final beat starts the solve. Sometimes the start comes on a stray beat instead.
  task automatic load_and_solve(int unsigned size_reg, int kind);
    int unsigned n;
    int cells[$];
    int j, t, total;
    bit stray_start;
    n = used_size(size_reg);
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) cells.push_back(r * 16 + c);
    for (int i = cells.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = cells[i];
      cells[i] = cells[j];
      cells[j] = t;
    end
    stray_start = ($urandom_range(0, 7) == 0);
    total = cells.size();
    foreach (cells[i]) begin
      if ($urandom_range(0, 9) == 0 && n < 15) begin
        send_beat(3'($urandom), 4'($urandom_range(n + 1, 15)), $urandom, 1'b0);
        noise_beats++;
      end
      send_beat(3'(cells[i] / 16), 4'(cells[i] % 16),
                pick_value(kind, cells[i] / 16, cells[i] % 16, n),
                !stray_start && i == total - 1);
      loaded_beats++;
    end
    if (stray_start) begin
      send_beat(3'($urandom), 4'($urandom_range(n + 1, 15)), $urandom, 1'b1);
      noise_beats++;
    end
  endtask

  // A one-unknown system for the directed part.
  task automatic solve_scalar(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] f);
    send_beat(3'd0, 4'd0, a, 1'b0);
    send_beat(3'd0, 4'd1, f, 1'b1);
    loaded_beats += 2;
  endtask

  initial begin
    int unsigned size_now;
    int kind;
    int phase;
    bit held;
    size_now = 8;
    held = 1'b0;
    phase = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on single-unknown systems: extremes, saturation, singular pivots,
    // a zero size and the threshold at both ends.
    write_reg(REG_SYSTEM_SIZE, 31'd1);
    write_reg(REG_SINGULAR_THRESHOLD, 31'd1);
    size_now = 1;
    solve_scalar(32'sh7FFF_FFFF, 32'sh8000_0000);
    solve_scalar(32'sh8000_0000, 32'sh8000_0000);
    solve_scalar(32'sh0000_0001, 32'sh7FFF_FFFF);
    solve_scalar(32'sh0000_0000, 32'sh0001_0000);
    solve_scalar(-32'sh0001_0000, 32'sh8000_0000);
    wait_idle();
    write_reg(REG_SYSTEM_SIZE, 31'd0);
    size_now = 0;
    send_beat(3'd7, 4'd8, $urandom, 1'b0);
    send_beat(3'd0, 4'd15, $urandom, 1'b0);
    noise_beats += 2;
    solve_scalar(-32'sh0001_0000, 32'sh0003_0000);
    wait_idle();
    write_reg(REG_SINGULAR_THRESHOLD, 31'h7FFF_FFFF);
    solve_scalar(32'sh7FFF_FFFF, 32'sh0001_0000);
    wait_idle();
    write_reg(REG_SINGULAR_THRESHOLD, 31'd0);
    solve_scalar(32'sh0000_0000, 32'sh0001_0000);
    solve_scalar(32'sh0000_0001, 32'sh0000_0001);
    wait_idle();

    // Random phases: each one sets the size (and usually the threshold) while idle and runs a few solves.
    while (loaded_beats < 210) begin
      wait_idle();
      phase++;
      gaps_on = (phase % 3 != 0);
      case ($urandom_range(0, 9))
        0: size_now = 8;
        1: size_now = 15;
        2: size_now = 0;
        default: size_now = $urandom_range(1, 4);
      endcase
      write_reg(REG_SYSTEM_SIZE, 31'(size_now));
      case ($urandom_range(0, 5))
        0: write_reg(REG_SINGULAR_THRESHOLD, 31'd0);
        1: write_reg(REG_SINGULAR_THRESHOLD, 31'($urandom_range(0, 131072)));
        2: write_reg(REG_SINGULAR_THRESHOLD, 31'($urandom));
        3: ;
        default: write_reg(REG_SINGULAR_THRESHOLD, 31'd1);
      endcase
      // Once, the receiver holds off while two systems go in back to back,
      // so the second load backs up behind the first solve.
      if (!held && phase >= 3 && used_size(size_now) <= 4) begin
        held = 1'b1;
        hold_req = 1'b1;
        load_and_solve(size_now, 0);
        hold_req = 1'b0;
        load_and_solve(size_now, 0);
      end
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        kind = kind < 7 ? 0 : (kind < 9 ? 1 : 2);
        load_and_solve(size_now, kind);
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Covered %0d load beats and %0d stray beats over %0d phases.",
             loaded_beats, noise_beats, phase);
    $display("%0d solves predicted: %0d singular, %0d with saturation; %0d mismatches.",
             solves, singulars, saturated, errors);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
